// ===== src/pixel_blend_mode_unit_top_assert.svh =====
// Assertion macros for the pixel blend mode unit top level.
`ifndef PIXEL_BLEND_MODE_UNIT_TOP_ASSERT_SVH
`define PIXEL_BLEND_MODE_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active
`define PBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked after a delay, disabled while reset is active
`define PBM_ASSERT_DLY(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== src/pbm_pkg.sv =====
// Shared types and constants for the pixel blend mode unit.
package pbm_pkg;

  // Blend mode codes
  typedef enum logic [3:0] {
    MODE_NORMAL   = 4'd0,
    MODE_MULTIPLY = 4'd1,
    MODE_SCREEN   = 4'd2,
    MODE_OVERLAY  = 4'd3,
    MODE_ADD      = 4'd4,
    MODE_SUB      = 4'd5,
    MODE_LIGHTEN  = 4'd6,
    MODE_DARKEN   = 4'd7,
    MODE_ALPHA    = 4'd8
  } mode_e;

  // Final step applied to the quotient in each lane
  typedef enum logic [1:0] {
    POST_DIV  = 2'd0,  // quotient, clamped
    POST_ADD  = 2'd1,  // val + quotient, saturating
    POST_SUB  = 2'd2,  // val - quotient, floored at zero
    POST_PASS = 2'd3   // val as is
  } post_e;

  // Configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegBlendMode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegOpacity   = CfgIdxW'(1);
  localparam logic [7:0]         OpacityReset = 8'd255;

  // Arithmetic constants: full weight 255*255, divisor 255^3
  localparam logic [15:0] FullW  = 16'd65025;
  localparam logic [23:0] FullD  = 24'd16581375;
  localparam logic [8:0]  RecipM = 9'd259;        // floor(2^32 / FullD)
  localparam logic [31:0] RoundC = 32'd16581120;  // 255 * 65024, makes a ceiling

  // Cycles from accept to result strobe
  localparam int unsigned Latency = 6;

  // Per-channel operands: q = (s*w + b*(FullW-w) + c) / FullD
  typedef struct packed {
    logic [15:0] s;
    logic [15:0] b;
    logic [15:0] w;
    logic        round_up;
    post_e       post;
    logic [7:0]  val;
  } lane_op_t;

  // Fields that ride along after the products are formed
  typedef struct packed {
    logic        round_up;
    post_e       post;
    logic [7:0]  val;
  } lane_tail_t;

endpackage

// ===== src/pixel_blend_mode_unit_top.sv =====
// Top level of the pixel blend mode unit: config registers, operand setup, four lanes.
// Throughput: one pixel per clock; the six-stage lane pipeline sets this, busy_o stays low.
// Reset: asynchronous, active low; clears all valid bits, mode to normal, opacity to 255.
// The result strobe lasts one cycle and the receiver cannot stall the pipeline.
`include "pixel_blend_mode_unit_top_assert.svh"

module pixel_blend_mode_unit_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [7:0]                   base_red_i,
  input  logic [7:0]                   base_green_i,
  input  logic [7:0]                   base_blue_i,
  input  logic [7:0]                   base_alpha_i,
  input  logic [7:0]                   paint_red_i,
  input  logic [7:0]                   paint_green_i,
  input  logic [7:0]                   paint_blue_i,
  input  logic [7:0]                   paint_alpha_i,
  output logic                         out_valid_o,
  output logic [7:0]                   out_red_o,
  output logic [7:0]                   out_green_o,
  output logic [7:0]                   out_blue_o,
  output logic [7:0]                   out_alpha_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);
  import pbm_pkg::*;

  logic [3:0]  mode_q;
  logic [7:0]  opacity_q;
  logic        accept;
  logic [15:0] w_pa, w_op;
  lane_op_t    lane_op [4];
  logic [3:0]  lane_vld;
  logic [7:0]  lane_res [4];

  // Operands for a color channel
  function automatic lane_op_t color_setup(logic [3:0] mode, logic [7:0] b, logic [7:0] p,
                                           logic [15:0] w);
    logic [7:0]  ma, mb;
    logic [15:0] prod, p255, b255;
    lane_op_t    r;
    ma   = b;
    mb   = p;
    if (mode == MODE_SCREEN || (mode == MODE_OVERLAY && b[7])) begin
      ma = ~b;  // 255 - b
      mb = ~p;
    end
    prod       = 16'(ma) * 16'(mb);
    p255       = {p, 8'd0} - {8'd0, p};
    b255       = {b, 8'd0} - {8'd0, b};
    r.s        = '0;
    r.b        = b255;
    r.w        = w;
    r.round_up = 1'b0;
    r.post     = POST_DIV;
    r.val      = b;
    case (mode)
      MODE_NORMAL:   r.s = p255;
      MODE_MULTIPLY: r.s = prod;
      MODE_SCREEN:   r.s = FullW - prod;
      MODE_OVERLAY: begin
        // dark base doubles the product, light base doubles the screen term
        r.s = b[7] ? FullW - {prod[14:0], 1'b0} : {prod[14:0], 1'b0};
      end
      MODE_ADD: begin
        r.s    = p255;
        r.b    = '0;
        r.post = POST_ADD;
      end
      MODE_SUB: begin
        r.s        = p255;
        r.b        = '0;
        r.round_up = 1'b1;
        r.post     = POST_SUB;
      end
      MODE_LIGHTEN: begin
        r.post = POST_PASS;
        r.val  = (b > p) ? b : p;
      end
      MODE_DARKEN: begin
        r.post = POST_PASS;
        r.val  = (b < p) ? b : p;
      end
      MODE_ALPHA: begin
        r.post = POST_PASS;
        r.val  = p;
      end
      default: r.post = POST_PASS;
    endcase
    return r;
  endfunction

  // Operands for the alpha channel
  function automatic lane_op_t alpha_setup(logic [3:0] mode, logic [7:0] ba, logic [7:0] pa,
                                           logic [15:0] w, logic [15:0] wo);
    logic [15:0] pa255, ba255;
    lane_op_t    r;
    pa255      = {pa, 8'd0} - {8'd0, pa};
    ba255      = {ba, 8'd0} - {8'd0, ba};
    r.s        = FullW;
    r.b        = ba255;
    r.w        = w;
    r.round_up = 1'b0;
    r.post     = POST_DIV;
    r.val      = ba;
    case (mode)
      MODE_NORMAL, MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY: r.post = POST_DIV;
      MODE_ADD: begin
        r.b    = '0;
        r.post = POST_ADD;
      end
      MODE_LIGHTEN, MODE_DARKEN: begin
        r.s = pa255;
        r.w = wo;
      end
      MODE_ALPHA: begin
        r.s = pa255;
        r.b = '0;
        r.w = wo;
      end
      default: r.post = POST_PASS;  // subtract and unlisted modes keep base alpha
    endcase
    return r;
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      opacity_q <= OpacityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegBlendMode) begin
        mode_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == RegOpacity) begin
        opacity_q <= cfg_data_i;
      end
    end
  end

  // Weights: opacity*brush alpha, and opacity scaled to full weight
  assign w_pa = 16'(opacity_q) * 16'(paint_alpha_i);
  assign w_op = {opacity_q, 8'd0} - {8'd0, opacity_q};

  always_comb begin
    lane_op[0] = color_setup(mode_q, base_red_i, paint_red_i, w_pa);
    lane_op[1] = color_setup(mode_q, base_green_i, paint_green_i, w_pa);
    lane_op[2] = color_setup(mode_q, base_blue_i, paint_blue_i, w_pa);
    lane_op[3] = alpha_setup(mode_q, base_alpha_i, paint_alpha_i, w_pa, w_op);
  end

  // Four channel pipelines
  for (genvar g = 0; g < 4; g++) begin : g_lane
    pbm_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (accept),
      .in_op_i    (lane_op[g]),
      .out_valid_o(lane_vld[g]),
      .out_data_o (lane_res[g])
    );
  end

  assign out_valid_o = lane_vld[0];
  assign out_red_o   = lane_res[0];
  assign out_green_o = lane_res[1];
  assign out_blue_o  = lane_res[2];
  assign out_alpha_o = lane_res[3];

  // Checks
  `PBM_ASSERT_IMP(a_lanes_agree, clk_i, rst_ni, 1'b1,
                  lane_vld == 4'b0000 || lane_vld == 4'b1111, "lane valid bits diverged")
  `PBM_ASSERT_DLY(a_latency, clk_i, rst_ni, accept, 6, out_valid_o,
                  "accepted word gave no result strobe")
  `PBM_ASSERT_DLY(a_unlisted_pass, clk_i, rst_ni, accept && mode_q > MODE_ALPHA, 6,
                  out_red_o == $past(base_red_i, 6) && out_alpha_o == $past(base_alpha_i, 6),
                  "unlisted mode did not pass the base pixel")

endmodule

// ===== src/pbm_lane.sv =====
// One channel of the blend pipeline: products, sum, divide by 255^3, final step.
module pbm_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pbm_pkg::lane_op_t in_op_i,
  output logic              out_valid_o,
  output logic [7:0]        out_data_o
);
  import pbm_pkg::*;

  logic [Latency-1:0] vld_d, vld_q;

  lane_op_t    op1_q;
  logic [31:0] p1_d, p1_q, p2_d, p2_q;
  logic [15:0] wc;
  lane_tail_t  tail2_q, tail3_q, tail4_q, tail5_q;
  logic [31:0] num3_d, num3_q, num4_q, num5_q;
  logic [40:0] prod4;
  logic [8:0]  qe4_d, qe4_q, qe5_q;
  logic [32:0] chk5_d, chk5_q;
  logic [32:0] rem6;
  logic [8:0]  qfix6, sum6;
  logic [7:0]  q6, res6_d, res6_q;

  // valid bits travel with the data
  assign vld_d = {vld_q[Latency-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 2: two products
  assign wc   = FullW - op1_q.w;
  assign p1_d = 32'(op1_q.s) * 32'(op1_q.w);
  assign p2_d = 32'(op1_q.b) * 32'(wc);

  // stage 3: numerator
  assign num3_d = p1_q + p2_q + (tail2_q.round_up ? RoundC : 32'd0);

  // stage 4: quotient estimate, low by at most one
  assign prod4 = 41'(num3_q) * 41'(RecipM);
  assign qe4_d = prod4[40:32];

  // stage 5: back-multiply for the correction
  assign chk5_d = 33'(qe4_q) * 33'(FullD);

  // stage 6: correct, clamp, final step
  always_comb begin
    rem6  = 33'(num5_q) - chk5_q;
    qfix6 = (rem6 >= 33'(FullD)) ? qe5_q + 9'd1 : qe5_q;
    q6    = qfix6[8] ? 8'hFF : qfix6[7:0];
    sum6  = 9'(tail5_q.val) + 9'(q6);
    case (tail5_q.post)
      POST_DIV:  res6_d = q6;
      POST_ADD:  res6_d = sum6[8] ? 8'hFF : sum6[7:0];
      POST_SUB:  res6_d = (tail5_q.val > q6) ? tail5_q.val - q6 : 8'd0;
      POST_PASS: res6_d = tail5_q.val;
      default:   res6_d = tail5_q.val;
    endcase
  end

  // payload registers, loaded only behind a valid word
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      op1_q <= in_op_i;
    end
    if (vld_q[0]) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      tail2_q <= '{round_up: op1_q.round_up, post: op1_q.post, val: op1_q.val};
    end
    if (vld_q[1]) begin
      num3_q  <= num3_d;
      tail3_q <= tail2_q;
    end
    if (vld_q[2]) begin
      qe4_q   <= qe4_d;
      num4_q  <= num3_q;
      tail4_q <= tail3_q;
    end
    if (vld_q[3]) begin
      chk5_q  <= chk5_d;
      qe5_q   <= qe4_q;
      num5_q  <= num4_q;
      tail5_q <= tail4_q;
    end
    if (vld_q[4]) begin
      res6_q <= res6_d;
    end
  end

  assign out_valid_o = vld_q[Latency-1];
  assign out_data_o  = res6_q;

endmodule
